FILE: rtl/core/pdpd_pkg.sv
// ----------------------------------------------------------------------------
// pdpd_pkg
// Types and constants shared by the priority-drop packet dispatcher.
// ----------------------------------------------------------------------------
package pdpd_pkg;

	localparam int SRC_W = 3;
	localparam int NUM_W = 16;
	localparam int DEV_W = 2;
	localparam int OCC_W = 4;
	localparam int CAP_W = 4;
	localparam int NDV_W = 3;
	localparam int CFG_W = 4;

	localparam logic FUNC_ARRIVAL   = 1'b0;
	localparam logic FUNC_DEPARTURE = 1'b1;

	localparam logic CFG_CAPACITY = 1'b0;
	localparam logic CFG_DEVICES  = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 4'd3;
	localparam logic [NDV_W-1:0] NDV_RESET = 3'd2;

	typedef struct packed {
		logic             func;
		logic [SRC_W-1:0] source;
		logic [DEV_W-1:0] device;
	} req_t;

	typedef struct packed {
		logic             dispatched;
		logic [DEV_W-1:0] disp_device;
		logic [SRC_W-1:0] disp_source;
		logic [NUM_W-1:0] disp_number;
		logic             rejected;
		logic [SRC_W-1:0] rej_source;
		logic [NUM_W-1:0] rej_number;
		logic [OCC_W-1:0] occupancy;
		logic             packet_valid;
		logic [SRC_W-1:0] packet_source;
	} rsp_t;

endpackage

FILE: rtl/core/pdpd_ram.sv
// ----------------------------------------------------------------------------
// pdpd_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module pdpd_ram #(
	parameter int W = 8,
	parameter int D = 8,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/priority_drop_packet_dispatcher.sv
// ----------------------------------------------------------------------------
// priority_drop_packet_dispatcher
// Buffers requests, drops by priority and dispatches them round-robin.
// ----------------------------------------------------------------------------
// Events enter on the req channel (valid/stall) and every event yields exactly
// one beat on the rsp channel (valid/stall). An arrival is numbered per source
// and started on a free device, or else buffered; a full buffer first drops
// its oldest entry of the highest source. A departure frees a device and may
// start a buffered request. Registers are written on the cfg channel, whose
// ready is always high; writes are meant for idle periods only.
// One event is handled at a time. An event with no buffer work passes through
// the count update (arrivals only), the fold of the start pointer after
// device_count is lowered, the round-robin device scan of up to device_count
// devices and the result state. Buffer work adds one pass over the held entries
// through the entry RAM read port, and a removal adds a second pass that
// moves the later entries down by one. The result sits in an output register,
// so a stalled receiver only holds the block once the next result is ready.
// Reset clears counts, device state and the packet source; no clearing pass.
// ----------------------------------------------------------------------------
module priority_drop_packet_dispatcher #(
	parameter int DEPTH   = 8,
	parameter int SOURCES = 8,
	parameter int DEVICES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  pdpd_pkg::req_t       req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output pdpd_pkg::rsp_t       rsp_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [pdpd_pkg::CFG_W-1:0] cfg_data
);

	import pdpd_pkg::*;

	localparam int EW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HW  = $clog2(DEPTH + 1);
	localparam int SIW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int DW  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam int DXW = $clog2(DEVICES + 1);
	localparam int EDW = SRC_W + NUM_W;

	typedef enum logic [3:0] {
		S_IDLE, S_CNT, S_NORM, S_SCAN, S_BUF, S_SEL, S_SHIFT, S_APPEND, S_FIN
	} state_t;

	state_t              state_q;
	logic                func_q;
	logic [SRC_W-1:0]    src_q;
	logic [NUM_W-1:0]    num_q;
	logic [DEVICES-1:0]  busy_q;
	logic [DXW-1:0]      ns_q;
	logic [DXW-1:0]      idx_q;
	logic [DXW-1:0]      cnt_q;
	logic [DXW-1:0]      fdev_q;
	logic [HW-1:0]       held_q;
	logic                pk_on_q;
	logic [SRC_W-1:0]    pk_src_q;
	logic [CAP_W-1:0]    cap_q;
	logic [NDV_W-1:0]    ndev_q;
	logic [SOURCES-1:0]  cvld_q;
	logic                cvld_s1;
	rsp_t                res_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;
	logic [HW-1:0]       rp_q;
	logic                rv_s1;
	logic [HW-1:0]       ri_s1;
	logic [HW-1:0]       mx_pos_q, mn_pos_q, mt_pos_q;
	logic [SRC_W-1:0]    mx_src_q, mn_src_q;
	logic [NUM_W-1:0]    mx_num_q, mn_num_q, mt_num_q;
	logic                mt_ok_q;

	logic [7:0]          cap_eff;
	logic [5:0]          ndev_eff;
	logic [DXW-1:0]      nv;
	logic                accept;
	logic                src_ok;
	logic                dev_ok;
	logic                drop_need;
	rsp_t                fin_rsp;

	logic                cnt_we;
	logic [SIW-1:0]      cnt_waddr, cnt_raddr;
	logic [NUM_W-1:0]    cnt_wdata, cnt_rdata;
	logic                ent_we;
	logic [EW-1:0]       ent_waddr, ent_raddr;
	logic [EDW-1:0]      ent_wdata, ent_rdata;
	logic [SRC_W-1:0]    rd_src;
	logic [NUM_W-1:0]    rd_num;
	logic [NUM_W-1:0]    cnt_next;

	assign cap_eff = (cap_q == '0) ? 8'd1 :
		((8'(cap_q) > 8'(DEPTH)) ? 8'(DEPTH) : 8'(cap_q));
	assign ndev_eff = (ndev_q == '0) ? 6'd1 :
		((6'(ndev_q) > 6'(DEVICES)) ? 6'(DEVICES) : 6'(ndev_q));
	assign nv        = DXW'(ndev_eff);
	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign src_ok    = (32'(src_q) < SOURCES);
	assign dev_ok    = (32'(req_data.device) < DEVICES);
	assign drop_need = (8'(held_q) >= cap_eff) && (held_q != '0);
	assign {rd_src, rd_num} = ent_rdata;
	assign cnt_next  = (cvld_s1 ? cnt_rdata : '0) + NUM_W'(1);

	assign cnt_raddr = SIW'(req_data.source);
	assign cnt_we    = (state_q == S_CNT);
	assign cnt_waddr = SIW'(src_q);
	assign cnt_wdata = cnt_next;

	always_comb begin
		fin_rsp               = res_q;
		fin_rsp.occupancy     = OCC_W'(held_q);
		fin_rsp.packet_valid  = pk_on_q;
		fin_rsp.packet_source = pk_on_q ? pk_src_q : '0;
	end

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = '0;
		ent_wdata = ent_rdata;
		ent_raddr = EW'(rp_q);
		if (state_q == S_SHIFT && rv_s1) begin
			ent_we    = 1'b1;
			ent_waddr = EW'(ri_s1 - HW'(1));
		end else if (state_q == S_APPEND && 32'(held_q) < DEPTH) begin
			ent_we    = 1'b1;
			ent_waddr = EW'(held_q);
			ent_wdata = {src_q, num_q};
		end
	end

	pdpd_ram #(.W(NUM_W), .D(SOURCES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	pdpd_ram #(.W(EDW), .D(DEPTH)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			func_q      <= FUNC_ARRIVAL;
			src_q       <= '0;
			num_q       <= '0;
			busy_q      <= '0;
			ns_q        <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			fdev_q      <= '0;
			held_q      <= '0;
			pk_on_q     <= 1'b0;
			pk_src_q    <= '0;
			cap_q       <= CAP_RESET;
			ndev_q      <= NDV_RESET;
			cvld_q      <= '0;
			cvld_s1     <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			rp_q        <= '0;
			rv_s1       <= 1'b0;
			ri_s1       <= '0;
			mx_pos_q    <= '0;
			mn_pos_q    <= '0;
			mt_pos_q    <= '0;
			mx_src_q    <= '0;
			mn_src_q    <= '0;
			mx_num_q    <= '0;
			mn_num_q    <= '0;
			mt_num_q    <= '0;
			mt_ok_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CAPACITY) begin
					cap_q <= cfg_data;
				end else begin
					ndev_q <= cfg_data[NDV_W-1:0];
				end
			end
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q  <= req_data.func;
						src_q   <= req_data.source;
						idx_q   <= ns_q;
						res_q   <= '0;
						cvld_s1 <= cvld_q[SIW'(req_data.source)];
						if (req_data.func == FUNC_ARRIVAL) begin
							if (32'(req_data.source) < SOURCES) begin
								state_q <= S_CNT;
							end else begin
								state_q <= S_FIN;
							end
						end else begin
							if (dev_ok) begin
								busy_q[DW'(req_data.device)] <= 1'b0;
							end
							state_q <= S_NORM;
						end
					end
				end
				S_CNT: begin
					num_q                <= cnt_next;
					cvld_q[SIW'(src_q)]  <= 1'b1;
					state_q              <= src_ok ? S_NORM : S_FIN;
				end
				S_NORM: begin
					if (idx_q >= nv) begin
						idx_q <= idx_q - nv;
					end else begin
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!busy_q[DW'(idx_q)] || cnt_q == nv - DXW'(1)) begin
						fdev_q <= idx_q;
						rp_q   <= '0;
						rv_s1  <= 1'b0;
						if (func_q == FUNC_ARRIVAL) begin
							if (!busy_q[DW'(idx_q)]) begin
								busy_q[DW'(idx_q)] <= 1'b1;
								ns_q <= (idx_q + DXW'(1) == nv) ? '0 : idx_q + DXW'(1);
								res_q.dispatched  <= 1'b1;
								res_q.disp_device <= DEV_W'(idx_q);
								res_q.disp_source <= src_q;
								res_q.disp_number <= num_q;
								state_q <= S_FIN;
							end else if (drop_need) begin
								state_q <= S_BUF;
							end else begin
								state_q <= S_APPEND;
							end
						end else begin
							if (!busy_q[DW'(idx_q)] && held_q != '0) begin
								state_q <= S_BUF;
							end else begin
								state_q <= S_FIN;
							end
						end
					end else begin
						idx_q <= (idx_q + DXW'(1) == nv) ? '0 : idx_q + DXW'(1);
						cnt_q <= cnt_q + DXW'(1);
					end
				end
				S_BUF: begin
					if (rp_q < held_q) begin
						rp_q  <= rp_q + HW'(1);
						rv_s1 <= 1'b1;
						ri_s1 <= rp_q;
					end else begin
						rv_s1 <= 1'b0;
					end
					if (rv_s1) begin
						if (ri_s1 == '0 || rd_src > mx_src_q) begin
							mx_pos_q <= ri_s1;
							mx_src_q <= rd_src;
							mx_num_q <= rd_num;
						end
						if (ri_s1 == '0 || rd_src < mn_src_q) begin
							mn_pos_q <= ri_s1;
							mn_src_q <= rd_src;
							mn_num_q <= rd_num;
						end
						if ((ri_s1 == '0 || !mt_ok_q) && rd_src == pk_src_q) begin
							mt_ok_q  <= 1'b1;
							mt_pos_q <= ri_s1;
							mt_num_q <= rd_num;
						end else if (ri_s1 == '0) begin
							mt_ok_q <= 1'b0;
						end
						if (ri_s1 == held_q - HW'(1)) begin
							state_q <= S_SEL;
						end
					end
				end
				S_SEL: begin
					rv_s1 <= 1'b0;
					if (func_q == FUNC_ARRIVAL) begin
						res_q.rejected   <= 1'b1;
						res_q.rej_source <= mx_src_q;
						res_q.rej_number <= mx_num_q;
						rp_q  <= mx_pos_q + HW'(1);
					end else begin
						res_q.dispatched  <= 1'b1;
						res_q.disp_device <= DEV_W'(fdev_q);
						busy_q[DW'(fdev_q)] <= 1'b1;
						ns_q <= (fdev_q + DXW'(1) == nv) ? '0 : fdev_q + DXW'(1);
						if (pk_on_q && mt_ok_q) begin
							res_q.disp_source <= pk_src_q;
							res_q.disp_number <= mt_num_q;
							rp_q  <= mt_pos_q + HW'(1);
						end else begin
							pk_on_q  <= 1'b1;
							pk_src_q <= mn_src_q;
							res_q.disp_source <= mn_src_q;
							res_q.disp_number <= mn_num_q;
							rp_q  <= mn_pos_q + HW'(1);
						end
					end
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (rp_q < held_q) begin
						rp_q  <= rp_q + HW'(1);
						rv_s1 <= 1'b1;
						ri_s1 <= rp_q;
					end else begin
						rv_s1 <= 1'b0;
						if (!rv_s1) begin
							held_q  <= held_q - HW'(1);
							state_q <= (func_q == FUNC_ARRIVAL) ? S_APPEND : S_FIN;
						end
					end
				end
				S_APPEND: begin
					if (32'(held_q) < DEPTH) begin
						held_q <= held_q + HW'(1);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= fin_rsp;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/pdpd_chk.sv
// ----------------------------------------------------------------------------
// pdpd_chk
// Port-level checks for the priority-drop packet dispatcher.
// ----------------------------------------------------------------------------
module pdpd_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input pdpd_pkg::rsp_t rsp_data
);

	import pdpd_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("Stalled response beat changed.");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("Second event taken while one is in progress.");

	a_disp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.dispatched |->
		rsp_data.disp_device == '0 && rsp_data.disp_source == '0 &&
		rsp_data.disp_number == '0)
		else $error("Dispatch fields set without a dispatch.");

	a_rej_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.rejected |-> !rsp_data.dispatched)
		else $error("Drop and dispatch reported in the same beat.");

	a_pkt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.packet_valid |-> rsp_data.packet_source == '0)
		else $error("Packet source shown without a packet.");

endmodule

bind priority_drop_packet_dispatcher pdpd_chk u_pdpd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

FILE: sim/tb_priority_drop_packet_dispatcher.sv
// ----------------------------------------------------------------------------
// tb_priority_drop_packet_dispatcher
// Drives arrival and departure events with random gaps and receiver stalls,
// predicts each result beat from its own model of the dispatcher and compares
// every field, over several register settings.
// ----------------------------------------------------------------------------
module tb_priority_drop_packet_dispatcher;
	import pdpd_pkg::*;

	localparam int DEPTH   = 8;
	localparam int SOURCES = 8;
	localparam int DEVICES = 4;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 2 * DEPTH + DEVICES + 16;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req_data;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	priority_drop_packet_dispatcher #(
		.DEPTH(DEPTH), .SOURCES(SOURCES), .DEVICES(DEVICES)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [SRC_W-1:0] mdl_src [DEPTH];
	logic [NUM_W-1:0] mdl_num [DEPTH];
	int               mdl_held = 0;
	logic [NUM_W-1:0] mdl_count [SOURCES] = '{default: '0};
	logic [DEVICES-1:0] mdl_busy = '0;
	int               mdl_next = 0;
	logic             mdl_pkt_on = 1'b0;
	logic [SRC_W-1:0] mdl_pkt_src = '0;
	logic [CAP_W-1:0] mdl_cap = CAP_RESET;
	logic [NDV_W-1:0] mdl_ndev = NDV_RESET;

	req_t  pending_events [$];
	rsp_t  expected_rsp [$];
	int    send_idle_pct;
	int    recv_idle_pct;
	bit    hold_recv;
	bit    failed;
	int    quiet_cycles;
	int    devs_now;

	function automatic int eff_cap();
		if (mdl_cap < 1) return 1;
		if (mdl_cap > DEPTH) return DEPTH;
		return int'(mdl_cap);
	endfunction

	function automatic int eff_devs();
		if (mdl_ndev < 1) return 1;
		if (mdl_ndev > DEVICES) return DEVICES;
		return int'(mdl_ndev);
	endfunction

	function automatic int find_idle_dev();
		int n;
		int idx;
		n = eff_devs();
		for (int i = 0; i < n; i++) begin
			idx = (mdl_next % n + i) % n;
			if (!mdl_busy[idx]) return idx;
		end
		return -1;
	endfunction

	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < mdl_held; i++) begin
			mdl_src[i] = mdl_src[i+1];
			mdl_num[i] = mdl_num[i+1];
		end
		mdl_held--;
	endfunction

	function automatic rsp_t dispatch_event(req_t ev);
		rsp_t r;
		int f;
		int pick;
		int worst;
		logic [NUM_W-1:0] num;
		r = '0;
		if (ev.func == FUNC_ARRIVAL) begin
			num = mdl_count[ev.source] + 1'b1;
			mdl_count[ev.source] = num;
			f = find_idle_dev();
			if (f >= 0) begin
				mdl_busy[f] = 1'b1;
				mdl_next = (f + 1) % eff_devs();
				r.dispatched = 1'b1;
				r.disp_device = DEV_W'(f);
				r.disp_source = ev.source;
				r.disp_number = num;
			end else begin
				if (mdl_held >= eff_cap() && mdl_held > 0) begin
					worst = 0;
					for (int i = 1; i < mdl_held; i++)
						if (mdl_src[i] > mdl_src[worst]) worst = i;
					r.rejected = 1'b1;
					r.rej_source = mdl_src[worst];
					r.rej_number = mdl_num[worst];
					drop_entry(worst);
				end
				if (mdl_held < DEPTH) begin
					mdl_src[mdl_held] = ev.source;
					mdl_num[mdl_held] = num;
					mdl_held++;
				end
			end
		end else begin
			mdl_busy[ev.device] = 1'b0;
			f = find_idle_dev();
			if (f >= 0 && mdl_held > 0) begin
				pick = mdl_held;
				if (mdl_pkt_on) begin
					for (int i = 0; i < mdl_held; i++)
						if (mdl_src[i] == mdl_pkt_src && pick == mdl_held) pick = i;
					if (pick == mdl_held) mdl_pkt_on = 1'b0;
				end
				if (pick == mdl_held) begin
					pick = 0;
					for (int i = 1; i < mdl_held; i++)
						if (mdl_src[i] < mdl_src[pick]) pick = i;
					mdl_pkt_on = 1'b1;
					mdl_pkt_src = mdl_src[pick];
				end
				r.dispatched = 1'b1;
				r.disp_device = DEV_W'(f);
				r.disp_source = mdl_src[pick];
				r.disp_number = mdl_num[pick];
				drop_entry(pick);
				mdl_busy[f] = 1'b1;
				mdl_next = (f + 1) % eff_devs();
			end
		end
		r.occupancy = OCC_W'(mdl_held);
		r.packet_valid = mdl_pkt_on;
		r.packet_source = mdl_pkt_on ? mdl_pkt_src : '0;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
		end else if (!req_valid || !req_stall) begin
			if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req_data  <= pending_events[0];
				expected_rsp.insert(expected_rsp.size(), dispatch_event(pending_events[0]));
				pending_events.delete(0);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$error("result beat with no expectation: %h", rsp_data);
					failed = 1'b1;
				end else begin
					rsp_t e;
					e = expected_rsp.pop_front();
					if (rsp_data.dispatched !== e.dispatched) begin
						$error("dispatched: expected %0d, got %0d", e.dispatched, rsp_data.dispatched);
						failed = 1'b1;
					end
					if (rsp_data.disp_device !== e.disp_device) begin
						$error("disp_device: expected %0d, got %0d", e.disp_device, rsp_data.disp_device);
						failed = 1'b1;
					end
					if (rsp_data.disp_source !== e.disp_source) begin
						$error("disp_source: expected %0d, got %0d", e.disp_source, rsp_data.disp_source);
						failed = 1'b1;
					end
					if (rsp_data.disp_number !== e.disp_number) begin
						$error("disp_number: expected %0d, got %0d", e.disp_number, rsp_data.disp_number);
						failed = 1'b1;
					end
					if (rsp_data.rejected !== e.rejected) begin
						$error("rejected: expected %0d, got %0d", e.rejected, rsp_data.rejected);
						failed = 1'b1;
					end
					if (rsp_data.rej_source !== e.rej_source) begin
						$error("rej_source: expected %0d, got %0d", e.rej_source, rsp_data.rej_source);
						failed = 1'b1;
					end
					if (rsp_data.rej_number !== e.rej_number) begin
						$error("rej_number: expected %0d, got %0d", e.rej_number, rsp_data.rej_number);
						failed = 1'b1;
					end
					if (rsp_data.occupancy !== e.occupancy) begin
						$error("occupancy: expected %0d, got %0d", e.occupancy, rsp_data.occupancy);
						failed = 1'b1;
					end
					if (rsp_data.packet_valid !== e.packet_valid) begin
						$error("packet_valid: expected %0d, got %0d", e.packet_valid, rsp_data.packet_valid);
						failed = 1'b1;
					end
					if (rsp_data.packet_source !== e.packet_source) begin
						$error("packet_source: expected %0d, got %0d", e.packet_source, rsp_data.packet_source);
						failed = 1'b1;
					end
				end
			end
			if (hold_recv) begin
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
		    (pending_events.size() == 0 && expected_rsp.size() == 0)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("priority_drop_packet_dispatcher: mismatch");
				$finish;
			end
		end
	end

	task automatic add_event(logic f, logic [SRC_W-1:0] s, logic [DEV_W-1:0] d);
		req_t ev;
		ev.func = f;
		ev.source = s;
		ev.device = d;
		pending_events.insert(pending_events.size(), ev);
	endtask

	task automatic drain();
		while (pending_events.size() > 0 || expected_rsp.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_CAPACITY) mdl_cap = val;
		else mdl_ndev = val[NDV_W-1:0];
		@(posedge clk);
	endtask

	// Mostly arrivals, with departures mostly from the enabled devices.
	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 55)
				add_event(FUNC_ARRIVAL, SRC_W'($urandom_range(7)), DEV_W'($urandom_range(3)));
			else
				add_event(FUNC_DEPARTURE, SRC_W'($urandom_range(7)),
					DEV_W'($urandom_range(100) < 90 ? $urandom_range(devs_now - 1)
						: $urandom_range(3)));
		end
	endtask

	task automatic run_phase(logic [CFG_W-1:0] cap, logic [CFG_W-1:0] ndev, int n);
		write_reg(CFG_CAPACITY, cap);
		write_reg(CFG_DEVICES, ndev);
		devs_now = eff_devs();
		add_random(n);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CAPACITY;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		devs_now = 2;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, fill devices, fill buffer, drop, serve.
		add_event(FUNC_ARRIVAL, 3'd7, 2'd3);
		add_event(FUNC_ARRIVAL, 3'd0, 2'd0);
		add_event(FUNC_ARRIVAL, 3'd5, 2'd0);
		add_event(FUNC_ARRIVAL, 3'd2, 2'd0);
		add_event(FUNC_ARRIVAL, 3'd7, 2'd0);
		add_event(FUNC_ARRIVAL, 3'd1, 2'd0);
		add_event(FUNC_ARRIVAL, 3'd2, 2'd0);
		add_event(FUNC_DEPARTURE, 3'd0, 2'd1);
		add_event(FUNC_DEPARTURE, 3'd7, 2'd1);
		add_event(FUNC_DEPARTURE, 3'd0, 2'd3);
		add_event(FUNC_DEPARTURE, 3'd0, 2'd0);
		add_event(FUNC_DEPARTURE, 3'd0, 2'd0);
		add_event(FUNC_DEPARTURE, 3'd0, 2'd1);
		add_event(FUNC_DEPARTURE, 3'd0, 2'd0);
		drain();
		// Capacity lowered below occupancy, out-of-range register values.
		write_reg(CFG_CAPACITY, 4'd8);
		write_reg(CFG_DEVICES, 4'd1);
		for (int i = 0; i < 7; i++) add_event(FUNC_ARRIVAL, SRC_W'(i), 2'd0);
		drain();
		write_reg(CFG_CAPACITY, 4'd0);
		write_reg(CFG_DEVICES, 4'd0);
		add_event(FUNC_ARRIVAL, 3'd6, 2'd0);
		add_event(FUNC_ARRIVAL, 3'd3, 2'd0);
		add_event(FUNC_DEPARTURE, 3'd0, 2'd0);
		drain();
		write_reg(CFG_CAPACITY, 4'd15);
		write_reg(CFG_DEVICES, 4'd7);
		add_event(FUNC_DEPARTURE, 3'd0, 2'd2);
		add_event(FUNC_DEPARTURE, 3'd0, 2'd3);
		drain();

		send_idle_pct = 21;
		recv_idle_pct = 46;
		run_phase(4'd3, 4'd2, 300);
		run_phase(4'd8, 4'd4, 250);
		// Long receiver hold-off while the sender keeps offering.
		fork
			begin
				hold_recv <= 1'b1;
				repeat (300) @(posedge clk);
				hold_recv <= 1'b0;
			end
		join_none
		run_phase(4'd1, 4'd1, 150);
		send_idle_pct = 46;
		recv_idle_pct = 21;
		run_phase(4'd5, 4'd3, 300);
		run_phase(4'd2, 4'd4, 200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(4'd8, 4'd1, 250);
		run_phase(4'd4, 4'd2, 250);

		if (!failed) begin
			$display("priority_drop_packet_dispatcher: match");
		end else begin
			$display("priority_drop_packet_dispatcher: mismatch");
		end
		$finish;
	end
endmodule

FILE: priority_drop_packet_dispatcher.f
rtl/core/pdpd_pkg.sv
rtl/core/pdpd_ram.sv
rtl/core/priority_drop_packet_dispatcher.sv
rtl/core/pdpd_chk.sv
sim/tb_priority_drop_packet_dispatcher.sv
